>>> rtl/pstt_pkg.sv
// Package for the priority-sorted task table.
// Holds table sizing constants, opcode and result-kind codes, and the
// command and status structs shared by the controller and the datapath.
`default_nettype none

package pstt_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int TALLY_W = 5;
    localparam int ID_W    = 8;
    localparam int PRI_W   = 8;

    typedef enum logic [1:0] {
        OP_INSERT    = 2'd0,
        OP_LIST_PEND = 2'd1,
        OP_PURGE     = 2'd2,
        OP_LIST_ALL  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        KIND_INSERTED = 3'd0,
        KIND_FULL     = 3'd1,
        KIND_ENTRY    = 3'd2,
        KIND_NONE     = 3'd3,
        KIND_PURGED   = 3'd4
    } kind_t;

    typedef struct packed {
        logic capture;
        logic scan_step;
        logic purge_step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic at_end;
        logic match;
        logic held_valid;
        logic out_free;
    } ctrl_stat_t;

endpackage

`default_nettype wire

>>> rtl/priority_sorted_task_table_unit.sv
// Top level of the priority-sorted task table.
// Joins the controller pstt_ctrl and the datapath pstt_datapath; uses pstt_pkg.
//
// Usage: one input channel (in_valid/in_stall with opcode, task_id,
// priority_req, completed) and one result channel (out_valid/out_stall with
// kind, entry_id, entry_priority, entry_completed, tally, last). A transfer
// happens on a rising edge where valid is high and stall is low.
// The table keeps up to 16 tasks sorted by descending priority, older first
// among equal priorities. An insert or a full-table drop gives one result.
// A purge walks the occupied slots, one per cycle. A listing also walks one
// slot per cycle while the output register is free to take a result; with
// two or more matching slots, its first result appears in the cycle after
// the second matching slot is read.
// The slot walk sets the rate: one item is in work at a time, and in_stall
// stays high until its last result is loaded into the output register.
// The next item is then taken while that result still waits to be taken.
// When out_stall is high the output register holds its result and a listing
// walk pauses at the next matching slot. Reset empties the table and clears
// all control state; the block leaves reset idle and ready for an item.
`default_nettype none

module priority_sorted_task_table_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    opcode,
    input  wire logic [pstt_pkg::ID_W-1:0]     task_id,
    input  wire logic [pstt_pkg::PRI_W-1:0]    priority_req,
    input  wire logic                          completed,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [2:0]                         kind,
    output logic [pstt_pkg::ID_W-1:0]          entry_id,
    output logic [pstt_pkg::PRI_W-1:0]         entry_priority,
    output logic                               entry_completed,
    output logic [pstt_pkg::TALLY_W-1:0]       tally,
    output logic                               last
);
    import pstt_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    pstt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    pstt_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .opcode          (opcode),
        .task_id         (task_id),
        .priority_req    (priority_req),
        .completed       (completed),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .entry_id        (entry_id),
        .entry_priority  (entry_priority),
        .entry_completed (entry_completed),
        .tally           (tally),
        .last            (last)
    );

endmodule

`default_nettype wire

>>> rtl/pstt_ctrl.sv
// Controller state machine of the priority-sorted task table.
// Sequences the datapath through capture, slot walks and the final result.
// Depends on pstt_pkg.
`default_nettype none

module pstt_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [1:0]           opcode,
    output logic                      in_stall,
    input  wire pstt_pkg::ctrl_stat_t stat,
    output pstt_pkg::ctrl_cmd_t       cmd
);
    import pstt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_PURGE = 4'b0100,
        ST_FINAL = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    unique case (opcode_t'(opcode))
                        OP_INSERT:    state_next = ST_FINAL;
                        OP_PURGE:     state_next = ST_PURGE;
                        OP_LIST_PEND: state_next = ST_SCAN;
                        OP_LIST_ALL:  state_next = ST_SCAN;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (stat.at_end)
                begin
                    state_next = ST_FINAL;
                end
                else if (!(stat.match && stat.held_valid && !stat.out_free))
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_PURGE:
            begin
                if (stat.at_end)
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    cmd.purge_step = 1'b1;
                end
            end
            ST_FINAL:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.scan_step, cmd.purge_step, cmd.finish}))
        else $error("More than one datapath command in a cycle.");

    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !in_stall)
        else $error("Block not ready after finishing an item.");

    a_capture_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> in_stall)
        else $error("Block ready right after capturing an item.");
`endif

endmodule

`default_nettype wire

>>> rtl/pstt_datapath.sv
// Datapath of the priority-sorted task table.
// Holds the slot registers, occupancy, walk counters and the output register.
// Depends on pstt_pkg.
`default_nettype none

module pstt_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pstt_pkg::ctrl_cmd_t           cmd,
    output pstt_pkg::ctrl_stat_t               stat,
    input  wire logic [1:0]                    opcode,
    input  wire logic [pstt_pkg::ID_W-1:0]     task_id,
    input  wire logic [pstt_pkg::PRI_W-1:0]    priority_req,
    input  wire logic                          completed,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [2:0]                         kind,
    output logic [pstt_pkg::ID_W-1:0]          entry_id,
    output logic [pstt_pkg::PRI_W-1:0]         entry_priority,
    output logic                               entry_completed,
    output logic [pstt_pkg::TALLY_W-1:0]       tally,
    output logic                               last
);
    import pstt_pkg::*;

    logic [ID_W-1:0]    slot_id_reg   [DEPTH];
    logic [PRI_W-1:0]   slot_pri_reg  [DEPTH];
    logic               slot_done_reg [DEPTH];
    logic [ID_W-1:0]    slot_id_next  [DEPTH];
    logic [PRI_W-1:0]   slot_pri_next [DEPTH];
    logic               slot_done_next[DEPTH];

    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic [CNT_W-1:0]   rd_reg, rd_next;
    logic [CNT_W-1:0]   wr_reg, wr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    opcode_t            op_reg, op_next;
    logic [ID_W-1:0]    new_id_reg, new_id_next;
    logic [PRI_W-1:0]   new_pri_reg, new_pri_next;
    logic               new_done_reg, new_done_next;

    logic               held_valid_reg, held_valid_next;
    logic [ID_W-1:0]    held_id_reg, held_id_next;
    logic [PRI_W-1:0]   held_pri_reg, held_pri_next;
    logic               held_done_reg, held_done_next;
    logic [TALLY_W-1:0] held_tally_reg, held_tally_next;

    logic               out_valid_reg, out_valid_next;
    kind_t              kind_reg, kind_next;
    logic [ID_W-1:0]    eid_reg, eid_next;
    logic [PRI_W-1:0]   epri_reg, epri_next;
    logic               edone_reg, edone_next;
    logic [TALLY_W-1:0] tally_reg, tally_next;
    logic               last_reg, last_next;

    logic               out_load;
    logic               out_free;
    logic [IDX_W-1:0]   rd_idx;
    logic [IDX_W-1:0]   wr_idx;
    logic               full;
    logic [DEPTH-1:0]   ge;
    logic [DEPTH-1:0]   prev_ge;

    assign rd_idx   = rd_reg[IDX_W-1:0];
    assign wr_idx   = wr_reg[IDX_W-1:0];
    assign full     = (occ_reg == CNT_W'(DEPTH));
    assign out_free = !out_valid_reg || !out_stall;

    assign stat.at_end     = (rd_reg >= occ_reg);
    assign stat.match      = (op_reg == OP_LIST_ALL) || !slot_done_reg[rd_idx];
    assign stat.held_valid = held_valid_reg;
    assign stat.out_free   = out_free;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ge[i] = (CNT_W'(i) < occ_reg) && (slot_pri_reg[i] >= new_pri_reg);
        end
        prev_ge = {ge[DEPTH-2:0], 1'b1};
    end

    always_comb
    begin
        slot_id_next    = slot_id_reg;
        slot_pri_next   = slot_pri_reg;
        slot_done_next  = slot_done_reg;
        occ_next        = occ_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        new_id_next     = new_id_reg;
        new_pri_next    = new_pri_reg;
        new_done_next   = new_done_reg;
        held_valid_next = held_valid_reg;
        held_id_next    = held_id_reg;
        held_pri_next   = held_pri_reg;
        held_done_next  = held_done_reg;
        held_tally_next = held_tally_reg;
        out_load        = 1'b0;
        kind_next       = KIND_NONE;
        eid_next        = '0;
        epri_next       = '0;
        edone_next      = 1'b0;
        tally_next      = '0;
        last_next       = 1'b1;

        if (cmd.capture)
        begin
            op_next         = opcode_t'(opcode);
            new_id_next     = task_id;
            new_pri_next    = priority_req;
            new_done_next   = completed;
            rd_next         = '0;
            wr_next         = '0;
            cnt_next        = '0;
            held_valid_next = 1'b0;
        end

        if (cmd.scan_step)
        begin
            rd_next = rd_reg + CNT_W'(1);
            if (stat.match)
            begin
                if (held_valid_reg)
                begin
                    out_load   = 1'b1;
                    kind_next  = KIND_ENTRY;
                    eid_next   = held_id_reg;
                    epri_next  = held_pri_reg;
                    edone_next = held_done_reg;
                    tally_next = held_tally_reg;
                    last_next  = 1'b0;
                end
                held_valid_next = 1'b1;
                held_id_next    = slot_id_reg[rd_idx];
                held_pri_next   = slot_pri_reg[rd_idx];
                held_done_next  = slot_done_reg[rd_idx];
                held_tally_next = TALLY_W'(cnt_reg + CNT_W'(1));
                cnt_next        = cnt_reg + CNT_W'(1);
            end
        end

        if (cmd.purge_step)
        begin
            rd_next = rd_reg + CNT_W'(1);
            if (!slot_done_reg[rd_idx])
            begin
                slot_id_next[wr_idx]   = slot_id_reg[rd_idx];
                slot_pri_next[wr_idx]  = slot_pri_reg[rd_idx];
                slot_done_next[wr_idx] = slot_done_reg[rd_idx];
                wr_next                = wr_reg + CNT_W'(1);
            end
        end

        if (cmd.finish)
        begin
            out_load = 1'b1;
            unique case (op_reg)
                OP_INSERT:
                begin
                    if (full)
                    begin
                        kind_next = KIND_FULL;
                    end
                    else
                    begin
                        kind_next = KIND_INSERTED;
                        occ_next  = occ_reg + CNT_W'(1);
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            if (!ge[i])
                            begin
                                if (prev_ge[i])
                                begin
                                    slot_id_next[i]   = new_id_reg;
                                    slot_pri_next[i]  = new_pri_reg;
                                    slot_done_next[i] = new_done_reg;
                                end
                                else if (i > 0)
                                begin
                                    slot_id_next[i]   = slot_id_reg[i-1];
                                    slot_pri_next[i]  = slot_pri_reg[i-1];
                                    slot_done_next[i] = slot_done_reg[i-1];
                                end
                            end
                        end
                    end
                end
                OP_PURGE:
                begin
                    kind_next  = KIND_PURGED;
                    tally_next = TALLY_W'(occ_reg - wr_reg);
                    occ_next   = wr_reg;
                end
                OP_LIST_PEND, OP_LIST_ALL:
                begin
                    if (held_valid_reg)
                    begin
                        kind_next  = KIND_ENTRY;
                        eid_next   = held_id_reg;
                        epri_next  = held_pri_reg;
                        edone_next = held_done_reg;
                        tally_next = held_tally_reg;
                    end
                end
            endcase
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg        <= '0;
            rd_reg         <= '0;
            wr_reg         <= '0;
            cnt_reg        <= '0;
            op_reg         <= OP_INSERT;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            occ_reg        <= occ_next;
            rd_reg         <= rd_next;
            wr_reg         <= wr_next;
            cnt_reg        <= cnt_next;
            op_reg         <= op_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_id_reg    <= slot_id_next;
        slot_pri_reg   <= slot_pri_next;
        slot_done_reg  <= slot_done_next;
        new_id_reg     <= new_id_next;
        new_pri_reg    <= new_pri_next;
        new_done_reg   <= new_done_next;
        held_id_reg    <= held_id_next;
        held_pri_reg   <= held_pri_next;
        held_done_reg  <= held_done_next;
        held_tally_reg <= held_tally_next;
        if (out_load)
        begin
            kind_reg  <= kind_next;
            eid_reg   <= eid_next;
            epri_reg  <= epri_next;
            edone_reg <= edone_next;
            tally_reg <= tally_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign entry_id        = eid_reg;
    assign entry_priority  = epri_reg;
    assign entry_completed = edone_reg;
    assign tally           = tally_reg;
    assign last            = last_reg;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("Occupancy exceeds the table depth.");

    a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
        wr_reg <= rd_reg)
        else $error("Purge write pointer passed the read pointer.");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("Output register loaded while a result is stalled.");
`endif

endmodule

`default_nettype wire

>>> sim/priority_sorted_task_table_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for priority_sorted_task_table_unit: a directed table, then
// random traffic under three idle mixes, each result checked against a sorted-table shadow.
// Depends on pstt_pkg and the RTL of the block; needs no files or arguments.

module priority_sorted_task_table_unit_tb;

    import pstt_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 40;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        kind_t              kind;
        logic [ID_W-1:0]    id;
        logic [PRI_W-1:0]   pri;
        logic               done;
        logic [TALLY_W-1:0] tally;
        logic               last;
    } task_result_t;

    typedef struct {
        logic [ID_W-1:0]    id;
        logic [PRI_W-1:0]   pri;
        logic               done;
    } task_slot_t;

    typedef struct packed {
        opcode_t            op;
        logic [ID_W-1:0]    id;
        logic [PRI_W-1:0]   pri;
        logic               done;
        logic [4:0]         reps;
        logic               typed;
        kind_t              typed_kind;
        logic [TALLY_W-1:0] typed_tally;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          opcode;
    logic [ID_W-1:0]     task_id;
    logic [PRI_W-1:0]    priority_req;
    logic                completed;
    logic                out_valid;
    logic                out_stall;
    logic [2:0]          kind;
    logic [ID_W-1:0]     entry_id;
    logic [PRI_W-1:0]    entry_priority;
    logic                entry_completed;
    logic [TALLY_W-1:0]  tally;
    logic                last;

    task_slot_t   shadow_slot [DEPTH];
    int           shadow_count = 0;
    task_result_t pending_results [$];
    int           mismatch_count = 0;
    int           send_idle_pct = 32;
    int           recv_idle_pct = 55;
    bit           hold_request = 1'b0;

    stim_row_t directed_rows [0:14] = '{
        '{OP_LIST_ALL,  8'h00, 8'h00, 1'b0, 5'd1,  1'b1, KIND_NONE,     5'd0},
        '{OP_LIST_PEND, 8'h00, 8'h00, 1'b0, 5'd1,  1'b1, KIND_NONE,     5'd0},
        '{OP_PURGE,     8'h00, 8'h00, 1'b0, 5'd1,  1'b1, KIND_PURGED,   5'd0},
        '{OP_INSERT,    8'h00, 8'h00, 1'b0, 5'd1,  1'b1, KIND_INSERTED, 5'd0},
        '{OP_INSERT,    8'hFF, 8'hFF, 1'b1, 5'd1,  1'b1, KIND_INSERTED, 5'd0},
        '{OP_INSERT,    8'h55, 8'hFF, 1'b0, 5'd1,  1'b1, KIND_INSERTED, 5'd0},
        '{OP_INSERT,    8'hAA, 8'h00, 1'b1, 5'd1,  1'b1, KIND_INSERTED, 5'd0},
        '{OP_LIST_ALL,  8'h00, 8'h00, 1'b0, 5'd1,  1'b0, KIND_NONE,     5'd0},
        '{OP_LIST_PEND, 8'h00, 8'h00, 1'b0, 5'd1,  1'b0, KIND_NONE,     5'd0},
        '{OP_INSERT,    8'h33, 8'h80, 1'b1, 5'd12, 1'b1, KIND_INSERTED, 5'd0},
        '{OP_INSERT,    8'hC3, 8'h7F, 1'b0, 5'd1,  1'b1, KIND_FULL,     5'd0},
        '{OP_LIST_ALL,  8'h00, 8'h00, 1'b0, 5'd1,  1'b0, KIND_NONE,     5'd0},
        '{OP_PURGE,     8'h00, 8'h00, 1'b0, 5'd1,  1'b0, KIND_NONE,     5'd0},
        '{OP_LIST_PEND, 8'h00, 8'h00, 1'b0, 5'd1,  1'b0, KIND_NONE,     5'd0},
        '{OP_LIST_ALL,  8'h00, 8'h00, 1'b0, 5'd1,  1'b0, KIND_NONE,     5'd0}
    };

    priority_sorted_task_table_unit DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .task_id         (task_id),
        .priority_req    (priority_req),
        .completed       (completed),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .entry_id        (entry_id),
        .entry_priority  (entry_priority),
        .entry_completed (entry_completed),
        .tally           (tally),
        .last            (last)
    );

    function automatic void predict_table_results(input opcode_t op,
                                                  input logic [ID_W-1:0] id,
                                                  input logic [PRI_W-1:0] pri,
                                                  input logic done,
                                                  ref task_result_t res [$]);
        int pos;
        int kept;
        int found;
        task_result_t r;
        res = {};
        r = '{KIND_INSERTED, '0, '0, 1'b0, '0, 1'b1};
        case (op)
            OP_INSERT:
            begin
                if (shadow_count >= DEPTH)
                begin
                    r.kind = KIND_FULL;
                end
                else
                begin
                    pos = 0;
                    while (pos < shadow_count && shadow_slot[pos].pri >= pri)
                        pos++;
                    for (int i = shadow_count; i > pos; i--)
                        shadow_slot[i] = shadow_slot[i - 1];
                    shadow_slot[pos] = '{id, pri, done};
                    shadow_count++;
                end
                res.push_back(r);
            end
            OP_PURGE:
            begin
                kept = 0;
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (!shadow_slot[i].done)
                    begin
                        shadow_slot[kept] = shadow_slot[i];
                        kept++;
                    end
                end
                r.kind = KIND_PURGED;
                r.tally = TALLY_W'(shadow_count - kept);
                shadow_count = kept;
                res.push_back(r);
            end
            default:
            begin
                found = 0;
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (op == OP_LIST_ALL || !shadow_slot[i].done)
                    begin
                        found++;
                        r.kind = KIND_ENTRY;
                        r.id = shadow_slot[i].id;
                        r.pri = shadow_slot[i].pri;
                        r.done = shadow_slot[i].done;
                        r.tally = TALLY_W'(found);
                        r.last = 1'b0;
                        res.push_back(r);
                    end
                end
                if (found == 0)
                begin
                    r.kind = KIND_NONE;
                    res.push_back(r);
                end
                else
                begin
                    res[res.size() - 1].last = 1'b1;
                end
            end
        endcase
    endfunction

    function automatic void note_mismatch(input string what, input task_result_t want,
                                          input task_result_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%0t: %s: expected kind %0d id %02h pri %02h done %0b tally %0d last %0b",
                     $time, what, want.kind, want.id, want.pri, want.done, want.tally,
                     want.last);
            $display("    got kind %0d id %02h pri %02h done %0b tally %0d last %0b",
                     got.kind, got.id, got.pri, got.done, got.tally, got.last);
        end
    endfunction

    task automatic transfer_item(input opcode_t op, input logic [ID_W-1:0] id,
                                 input logic [PRI_W-1:0] pri, input logic done,
                                 input logic typed, input kind_t typed_kind,
                                 input logic [TALLY_W-1:0] typed_tally);
        task_result_t res [$];
        in_valid <= 1'b1;
        opcode <= op;
        task_id <= id;
        priority_req <= pri;
        completed <= done;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_table_results(op, id, pri, done, res);
        if (typed)
            pending_results.push_back('{typed_kind, '0, '0, 1'b0, typed_tally, 1'b1});
        else
            foreach (res[i])
                pending_results.push_back(res[i]);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic run_random(input int count, input int insert_pct);
        opcode_t op;
        int pick;
        logic [PRI_W-1:0] pri;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < insert_pct)
                op = OP_INSERT;
            else if (pick < insert_pct + (100 - insert_pct) / 3)
                op = OP_LIST_PEND;
            else if (pick < insert_pct + 2 * (100 - insert_pct) / 3)
                op = OP_LIST_ALL;
            else
                op = OP_PURGE;
            if ($urandom_range(1) == 1)
                pri = PRI_W'(85 * $urandom_range(3));
            else
                pri = PRI_W'($urandom_range(255));
            transfer_item(op, ID_W'($urandom_range(255)), pri, 1'($urandom_range(1)),
                          1'b0, KIND_INSERTED, '0);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("priority_sorted_task_table_unit_tb: done, errors");
        $finish;
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        task_result_t want;
        task_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{kind_t'(kind), entry_id, entry_priority, entry_completed, tally, last};
            if (pending_results.size() == 0)
            begin
                want = '{KIND_NONE, '0, '0, 1'b0, '0, 1'b0};
                note_mismatch("result with nothing expected", want, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind || got.id !== want.id || got.pri !== want.pri ||
                    got.done !== want.done || got.tally !== want.tally ||
                    got.last !== want.last)
                    note_mismatch("result mismatch", want, got);
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        opcode <= OP_INSERT;
        task_id <= '0;
        priority_req <= '0;
        completed <= 1'b0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
            repeat (directed_rows[k].reps)
                transfer_item(directed_rows[k].op, directed_rows[k].id, directed_rows[k].pri,
                              directed_rows[k].done, directed_rows[k].typed,
                              directed_rows[k].typed_kind, directed_rows[k].typed_tally);

        run_random(150, 50);
        send_idle_pct = 55;
        recv_idle_pct = 32;
        run_random(150, 60);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(60, 50);
        hold_request = 1'b1;
        run_random(84, 50);
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("priority_sorted_task_table_unit_tb: done, clean");
        else
            $display("priority_sorted_task_table_unit_tb: done, errors");
        $finish;
    end

endmodule

>>> sim.f
rtl/pstt_pkg.sv
rtl/pstt_ctrl.sv
rtl/pstt_datapath.sv
rtl/priority_sorted_task_table_unit.sv
sim/priority_sorted_task_table_unit_tb.sv
